/* sv/tgsd_pkg.sv */
// Shared constants, command/status structs for the two-gate speed detector.
`default_nettype none
package tgsd_pkg;

  // Field widths
  localparam int TIME_MS_W     = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int SPEED_W       = 16;
  localparam int DIR_W         = 2;

  // Default for the stored time width
  localparam int TIME_BITS_DEF = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] GATE_SPACING_RST = 16'd1000;
  localparam logic [CFG_W-1:0] PAIR_WINDOW_RST  = 16'd1500;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd20;

  // Speed arithmetic: spacing * 1000 / dt, 65535 * 1000 fits in 26 bits
  localparam int SCALE     = 1000;
  localparam int DVD_W     = 26;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

  // Direction codes
  localparam logic signed [DIR_W-1:0] DIR_A_TO_B = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_B_TO_A = 2'sb11;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // register the accepted sample
    logic eval;      // pair / timeout decision, divider load
    logic div_step;  // one divider iteration
    logic out_load;  // move quotient into the output register
  } tgsd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pair;      // both edges valid and within the window
    logic div_busy;  // divider iterations remaining
  } tgsd_sts_t;

endpackage
`default_nettype wire

/* sv/tgsd_if.sv */
// Channel interfaces: sample input, event output, configuration writes.
`default_nettype none
interface tgsd_in_if
  import tgsd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 present_a;
  logic                 present_b;
  logic [TIME_MS_W-1:0] time_ms;

  modport source (output valid, output present_a, output present_b, output time_ms,
                  input ready);
  modport sink   (input valid, input present_a, input present_b, input time_ms,
                  output ready);
endinterface

interface tgsd_out_if
  import tgsd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SPEED_W-1:0]      speed_mm_per_s;
  logic signed [DIR_W-1:0] direction;

  modport source (output valid, output speed_mm_per_s, output direction, input ready);
  modport sink   (input valid, input speed_mm_per_s, input direction, output ready);
endinterface

interface tgsd_cfg_if
  import tgsd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/two_gate_speed_direction_detector_core.sv */
// Top level of the two-gate speed and direction detector.
// Each accepted sample updates the rising-edge times of gates A and B. When both
// gates hold edge times no more than pairing_window_ms apart, one result is
// produced: speed = gate_spacing_mm * 1000 / max(dt, min_interval_ms), saturated
// at 65535, and direction +1 for A before B, otherwise -1; the held times are then
// cleared. Any held time older than the window clears both held times. A sample that
// gives no result is accepted and then evaluated; a sample that gives a result is
// accepted, evaluated, divided by the 26-iteration bit-serial divider and then loaded
// into the output, which waits while the output register is still full. The result waits in an output
// register, so the next sample is taken while it is still pending. Configuration
// writes are always accepted and take effect on the next cycle.
`default_nettype none
module two_gate_speed_direction_detector_core
  import tgsd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tgsd_cfg_if.sink   cfg_i,
  tgsd_in_if.sink    in_i,
  tgsd_out_if.source out_o
);

  tgsd_cmd_t cmd;
  tgsd_sts_t sts;

  // Configuration port never stalls
  assign cfg_i.ready = 1'b1;

  tgsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tgsd_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .present_a_i (in_i.present_a),
    .present_b_i (in_i.present_b),
    .time_ms_i   (in_i.time_ms),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .speed_o     (out_o.speed_mm_per_s),
    .direction_o (out_o.direction)
  );

endmodule
`default_nettype wire

/* sv/tgsd_ctrl.sv */
// Controller state machine: sequences capture, evaluation, division, output.
`default_nettype none
module tgsd_ctrl
  import tgsd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  input  wire tgsd_sts_t sts_i,
  output tgsd_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.pair ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  // A matched pair always starts a division
  a_pair_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && sts_i.pair) |=> (state_q == S_DIV && sts_i.div_busy))
    else $error("pair did not start the divider");

  // An accepted sample is evaluated on the next cycle
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_EVAL)
    else $error("accepted sample not evaluated");

endmodule
`default_nettype wire

/* sv/tgsd_dp.sv */
// Datapath: config registers, edge time tracking, bit-serial speed divider.
`default_nettype none
module tgsd_dp
  import tgsd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 present_a_i,
  input  wire logic                 present_b_i,
  input  wire logic [TIME_MS_W-1:0] time_ms_i,
  input  wire tgsd_cmd_t            cmd_i,
  output tgsd_sts_t                 sts_o,
  output logic [SPEED_W-1:0]        speed_o,
  output logic signed [DIR_W-1:0]   direction_o
);

  // Configuration registers
  logic [CFG_W-1:0] spacing_q, window_q, min_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= GATE_SPACING_RST;
      window_q  <= PAIR_WINDOW_RST;
      min_int_q <= MIN_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GATE_SPACING: spacing_q <= cfg_data_i;
        REG_PAIR_WINDOW:  window_q  <= cfg_data_i;
        REG_MIN_INTERVAL: min_int_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Edge tracking state
  logic                 last_a_q, last_b_q;
  logic                 valid_a_q, valid_b_q;
  logic [TIME_BITS-1:0] time_a_q, time_b_q, now_q;
  logic [TIME_BITS-1:0] now_in;
  logic                 rise_a, rise_b;

  assign now_in = TIME_BITS'(time_ms_i);
  assign rise_a = present_a_i && !last_a_q;
  assign rise_b = present_b_i && !last_b_q;

  // Pair and timeout decision on the stored edges
  logic [TIME_BITS-1:0] win_ext, diff_ba, diff_ab, span, age_a, age_b;
  logic                 pair, stale, a_first;
  logic [CFG_W-1:0]     min_eff, dt;

  assign win_ext = TIME_BITS'(window_q);
  assign diff_ba = time_b_q - time_a_q;
  assign diff_ab = time_a_q - time_b_q;
  assign span    = diff_ba[TIME_BITS-1] ? diff_ab : diff_ba;
  assign pair    = valid_a_q && valid_b_q && (span <= win_ext);
  assign age_a   = now_q - time_a_q;
  assign age_b   = now_q - time_b_q;
  assign stale   = (valid_a_q && (age_a > win_ext)) || (valid_b_q && (age_b > win_ext));
  assign a_first = (diff_ba != '0) && !diff_ba[TIME_BITS-1];

  // span fits 16 bits whenever a pair is taken; zero minimum acts as one
  assign min_eff = (min_int_q == '0) ? CFG_W'(1) : min_int_q;
  assign dt      = (span[CFG_W-1:0] < min_eff) ? min_eff : span[CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q  <= 1'b0;
      last_b_q  <= 1'b0;
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      time_a_q  <= '0;
      time_b_q  <= '0;
    end else if (cmd_i.capture) begin
      last_a_q <= present_a_i;
      last_b_q <= present_b_i;
      if (rise_a) begin
        time_a_q  <= now_in;
        valid_a_q <= 1'b1;
      end
      if (rise_b) begin
        time_b_q  <= now_in;
        valid_b_q <= 1'b1;
      end
    end else if (cmd_i.eval && (pair || stale)) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      time_a_q  <= '0;
      time_b_q  <= '0;
    end
  end

  // Sample time, held for the age check
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= now_in;
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [CNT_W-1:0]   cnt_q;
  logic [CFG_W-1:0]   rem_q, divisor_q;
  logic [DVD_W-1:0]   quo_q, dividend;
  logic [CFG_W:0]     shifted, trial;
  logic               fits;
  logic signed [DIR_W-1:0] dir_q;

  assign dividend = DVD_W'(spacing_q) * DVD_W'(SCALE);
  assign shifted  = {rem_q, quo_q[DVD_W-1]};
  assign trial    = shifted - {1'b0, divisor_q};
  assign fits     = shifted >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.eval && pair) begin
      cnt_q <= CNT_W'(DIV_STEPS);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && pair) begin
      rem_q     <= '0;
      quo_q     <= dividend;
      divisor_q <= dt;
      dir_q     <= a_first ? DIR_A_TO_B : DIR_B_TO_A;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      rem_q <= fits ? trial[CFG_W-1:0] : shifted[CFG_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  // Output payload register with saturation
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      speed_o     <= (|quo_q[DVD_W-1:SPEED_W]) ? SPEED_MAX : quo_q[SPEED_W-1:0];
      direction_o <= dir_q;
    end
  end

  assign sts_o.pair     = pair;
  assign sts_o.div_busy = (cnt_q != '0);

  // Both edges are released after an event
  a_pair_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && pair) |=> (!valid_a_q && !valid_b_q))
    else $error("edges not cleared after an event");

  // Quotient only taken once all iterations are done
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (cnt_q == '0))
    else $error("result taken from an unfinished division");

endmodule
`default_nettype wire
